// ===== rtl/core/dfbp_pkg.sv =====
package dfbp_pkg;

	localparam logic [7:0] FIXED_LEN  = 8'd236;
	localparam logic [7:0] OPTS_START = 8'd240;
	localparam logic [7:0] COOKIE_A   = 8'h63;
	localparam logic [7:0] COOKIE_B   = 8'h82;
	localparam logic [7:0] COOKIE_C   = 8'h53;
	localparam int         BCAST_BIT  = 7;
	localparam logic [7:0] OPT_PAD    = 8'd0;
	localparam logic [7:0] OPT_END    = 8'd255;

	localparam logic [7:0] CHADDR_START = 8'd28;
	localparam logic [7:0] SNAME_START  = 8'd44;
	localparam logic [7:0] FILE_START   = 8'd108;

	// record kinds
	localparam logic [2:0] KIND_HEADER    = 3'd0;
	localparam logic [2:0] KIND_NAME      = 3'd1;
	localparam logic [2:0] KIND_OPT_START = 3'd2;
	localparam logic [2:0] KIND_OPT_DATA  = 3'd3;
	localparam logic [2:0] KIND_STATUS    = 3'd4;

	// field ids
	localparam logic [3:0] FID_OP     = 4'd0;
	localparam logic [3:0] FID_HTYPE  = 4'd1;
	localparam logic [3:0] FID_HLEN   = 4'd2;
	localparam logic [3:0] FID_HOPS   = 4'd3;
	localparam logic [3:0] FID_XID    = 4'd4;
	localparam logic [3:0] FID_SECS   = 4'd5;
	localparam logic [3:0] FID_BCAST  = 4'd6;
	localparam logic [3:0] FID_CIADDR = 4'd7;
	localparam logic [3:0] FID_YIADDR = 4'd8;
	localparam logic [3:0] FID_SIADDR = 4'd9;
	localparam logic [3:0] FID_GIADDR = 4'd10;
	localparam logic [3:0] FID_CHADDR = 4'd11;
	localparam logic [3:0] FID_SNAME  = 4'd12;
	localparam logic [3:0] FID_FILE   = 4'd13;

	// frame status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_SHORT      = 2'd1;
	localparam logic [1:0] ST_BAD_COOKIE = 2'd2;
	localparam logic [1:0] ST_NO_END     = 2'd3;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2
	} opt_phase_t;

	typedef struct packed {
		logic [2:0]  record_kind;
		logic [3:0]  field_id;
		logic [31:0] field_value;
		logic [7:0]  byte_offset;
		logic [7:0]  option_code;
		logic [7:0]  option_length;
		logic [1:0]  frame_status;
		logic        last;
	} rec_t;

	// results of one byte: at most one data record, then maybe the status
	typedef struct packed {
		logic       has_data;
		rec_t       data;
		logic       has_status;
		logic [1:0] status;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

endpackage

// ===== rtl/core/dfbp_front.sv =====
module dfbp_front
	import dfbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	output push_t      push
);

	logic       emit_q;
	logic [7:0] pos_q, pos_d;
	logic [23:0] acc_q;
	opt_phase_t phase_q, phase_d;
	logic [7:0] code_q, code_d;
	logic [7:0] len_q, len_d;
	logic [7:0] idx_q, idx_d;
	logic       cookie_q, cookie_d;
	logic       ended_q, ended_d;

	logic        accept;
	logic [31:0] acc32;
	logic        hdr_hit;
	logic [3:0]  hdr_fid;
	logic [31:0] hdr_val;
	logic [7:0]  want;
	logic [7:0]  idx_inc;
	rec_t        rec;
	logic        has_data;
	logic [1:0]  status;

	assign accept = in_valid && !in_stall;
	assign acc32  = {acc_q, data_byte};
	assign idx_inc = idx_q + 8'd1;

	always_comb begin
		hdr_hit = 1'b1;
		hdr_fid = FID_OP;
		hdr_val = 32'd0;
		case (pos_q)
			8'd0: begin hdr_fid = FID_OP;     hdr_val = {24'd0, data_byte}; end
			8'd1: begin hdr_fid = FID_HTYPE;  hdr_val = {24'd0, data_byte}; end
			8'd2: begin hdr_fid = FID_HLEN;   hdr_val = {24'd0, data_byte}; end
			8'd3: begin hdr_fid = FID_HOPS;   hdr_val = {24'd0, data_byte}; end
			8'd7: begin hdr_fid = FID_XID;    hdr_val = acc32; end
			8'd9: begin hdr_fid = FID_SECS;   hdr_val = {16'd0, acc32[15:0]}; end
			8'd10: begin
				hdr_fid = FID_BCAST;
				hdr_val = {31'd0, data_byte[BCAST_BIT]};
			end
			8'd15: begin hdr_fid = FID_CIADDR; hdr_val = acc32; end
			8'd19: begin hdr_fid = FID_YIADDR; hdr_val = acc32; end
			8'd23: begin hdr_fid = FID_SIADDR; hdr_val = acc32; end
			8'd27: begin hdr_fid = FID_GIADDR; hdr_val = acc32; end
			default: hdr_hit = 1'b0;
		endcase
	end

	always_comb begin
		case (pos_q)
			8'd236:  want = COOKIE_A;
			8'd237:  want = COOKIE_B;
			8'd238:  want = COOKIE_C;
			default: want = COOKIE_A;
		endcase
	end

	always_comb begin
		pos_d    = pos_q;
		phase_d  = phase_q;
		code_d   = code_q;
		len_d    = len_q;
		idx_d    = idx_q;
		cookie_d = cookie_q;
		ended_d  = ended_q;
		rec      = '0;
		has_data = 1'b0;

		if (pos_q < FIXED_LEN) begin
			if (hdr_hit) begin
				has_data        = 1'b1;
				rec.record_kind = KIND_HEADER;
				rec.field_id    = hdr_fid;
				rec.field_value = hdr_val;
			end else if (emit_q && pos_q >= CHADDR_START) begin
				has_data        = 1'b1;
				rec.record_kind = KIND_NAME;
				rec.field_value = {24'd0, data_byte};
				if (pos_q < SNAME_START) begin
					rec.field_id    = FID_CHADDR;
					rec.byte_offset = pos_q - CHADDR_START;
				end else if (pos_q < FILE_START) begin
					rec.field_id    = FID_SNAME;
					rec.byte_offset = pos_q - SNAME_START;
				end else begin
					rec.field_id    = FID_FILE;
					rec.byte_offset = pos_q - FILE_START;
				end
			end
		end else if (pos_q < OPTS_START) begin
			if (pos_q == FIXED_LEN) begin
				cookie_d = (data_byte == want);
			end else if (data_byte != want) begin
				cookie_d = 1'b0;
			end
		end else if (cookie_q && !ended_q) begin
			unique case (phase_q)
				PH_LEN: begin
					has_data          = 1'b1;
					rec.record_kind   = KIND_OPT_START;
					rec.option_code   = code_q;
					rec.option_length = data_byte;
					len_d   = data_byte;
					idx_d   = 8'd0;
					phase_d = (data_byte == 8'd0) ? PH_CODE : PH_DATA;
				end
				PH_DATA: begin
					has_data          = 1'b1;
					rec.record_kind   = KIND_OPT_DATA;
					rec.field_value   = {24'd0, data_byte};
					rec.byte_offset   = idx_q;
					rec.option_code   = code_q;
					rec.option_length = len_q;
					idx_d = idx_inc;
					if (idx_inc >= len_q) phase_d = PH_CODE;
				end
				default: begin
					// unused phase code behaves as expect code
					if (data_byte == OPT_END) begin
						ended_d = 1'b1;
						phase_d = PH_CODE;
					end else if (data_byte != OPT_PAD) begin
						code_d  = data_byte;
						phase_d = PH_LEN;
					end else begin
						phase_d = PH_CODE;
					end
				end
			endcase
		end

		if (pos_q < OPTS_START) pos_d = pos_q + 8'd1;

		if (pos_d < FIXED_LEN)                   status = ST_SHORT;
		else if (pos_d == FIXED_LEN)             status = ST_OK;
		else if (pos_d < OPTS_START || !cookie_d) status = ST_BAD_COOKIE;
		else                                     status = ended_d ? ST_OK : ST_NO_END;
	end

	always_comb begin
		push.entry.has_data   = has_data;
		push.entry.data       = rec;
		push.entry.has_status = frame_end;
		push.entry.status     = status;
		push.push             = accept && (has_data || frame_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b1;
		end else if (cfg_wr_en) begin
			emit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 8'd0;
			acc_q    <= 24'd0;
			phase_q  <= PH_CODE;
			code_q   <= 8'd0;
			len_q    <= 8'd0;
			idx_q    <= 8'd0;
			cookie_q <= 1'b0;
			ended_q  <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q    <= 8'd0;
				acc_q    <= 24'd0;
				phase_q  <= PH_CODE;
				code_q   <= 8'd0;
				len_q    <= 8'd0;
				idx_q    <= 8'd0;
				cookie_q <= 1'b0;
				ended_q  <= 1'b0;
			end else begin
				pos_q    <= pos_d;
				acc_q    <= acc32[23:0];
				phase_q  <= phase_d;
				code_q   <= code_d;
				len_q    <= len_d;
				idx_q    <= idx_d;
				cookie_q <= cookie_d;
				ended_q  <= ended_d;
			end
		end
	end

endmodule

// ===== rtl/core/dfbp_queue.sv =====
module dfbp_queue
	import dfbp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output logic   full,
	output logic   empty,
	output entry_t head
);

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_pop;

	assign full   = (count_q == (QAW+1)'(QDEPTH));
	assign empty  = (count_q == '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push.push) mem_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (do_pop)    rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push.push && !do_pop)      count_q <= count_q + (QAW+1)'(1);
			else if (!push.push && do_pop) count_q <= count_q - (QAW+1)'(1);
		end
	end

endmodule

// ===== rtl/core/dfbp_back.sv =====
module dfbp_back
	import dfbp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   empty,
	input  entry_t head,
	output logic   pop,
	input  logic   out_stall,
	output logic   out_valid,
	output rec_t   out_rec
);

	logic       valid_q;
	rec_t       rec_q;
	logic       pend_q;
	logic [1:0] pend_st_q;
	logic       out_free;
	rec_t       st_rec;

	assign out_free  = !valid_q || !out_stall;
	assign pop       = out_free && !pend_q && !empty;
	assign out_valid = valid_q;
	assign out_rec   = rec_q;

	always_comb begin
		st_rec              = '0;
		st_rec.record_kind  = KIND_STATUS;
		st_rec.last         = 1'b1;
		st_rec.frame_status = pend_q ? pend_st_q : head.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!empty) begin
				valid_q <= 1'b1;
				pend_q  <= head.has_data && head.has_status;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				rec_q <= st_rec;
			end else if (!empty) begin
				rec_q     <= head.has_data ? head.data : st_rec;
				pend_st_q <= head.status;
			end
		end
	end

endmodule

// ===== rtl/core/dhcp_frame_byte_parser.sv =====
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// input    | in_valid / in_stall  | data_byte, frame_end
// output   | out_valid / out_stall| record_kind .. last, one record per transaction
// config   | cfg_wr_en            | cfg_wr_data (emit_name_bytes)
//
// one input byte per cycle when not stalled; the front end classifies it combinationally
// a byte yields zero, one or two records; the output register sends one record per cycle
// unless out_stall holds it, so a data record plus the frame status go out as two records
// a four-entry queue between front end and output decouples both sides; in_stall rises
// only while the queue is full
// reset (arst_n low) clears frame state, empties the queue, and sets emit_name_bytes to 1
module dhcp_frame_byte_parser
	import dfbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	// record output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  record_kind,
	output logic [3:0]  field_id,
	output logic [31:0] field_value,
	output logic [7:0]  byte_offset,
	output logic [7:0]  option_code,
	output logic [7:0]  option_length,
	output logic [1:0]  frame_status,
	output logic        last,
	// configuration
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);

	push_t  push;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;
	entry_t q_head;
	rec_t   rec;

	// front end may push every cycle, so stall whenever no slot is free
	assign in_stall = q_full;

	dfbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push       (push)
	);

	// per-byte result entries waiting to be serialized
	dfbp_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (q_pop),
		.full  (q_full),
		.empty (q_empty),
		.head  (q_head)
	);

	// sends an entry's data record, if any, then its status record, if any
	dfbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (q_head),
		.pop      (q_pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_rec  (rec)
	);

	assign record_kind   = rec.record_kind;
	assign field_id      = rec.field_id;
	assign field_value   = rec.field_value;
	assign byte_offset   = rec.byte_offset;
	assign option_code   = rec.option_code;
	assign option_length = rec.option_length;
	assign frame_status  = rec.frame_status;
	assign last          = rec.last;

endmodule

// ===== verif/tb.sv =====
module tb;
	import dfbp_pkg::*;

	// one input byte as the driver sends it
	typedef struct packed {
		logic [7:0] value;
		logic       fend;
	} byte_item_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte   = 8'd0;
	logic        frame_end   = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [2:0]  record_kind;
	logic [3:0]  field_id;
	logic [31:0] field_value;
	logic [7:0]  byte_offset;
	logic [7:0]  option_code;
	logic [7:0]  option_length;
	logic [1:0]  frame_status;
	logic        last;
	logic        cfg_wr_en   = 1'b0;
	logic        cfg_wr_data = 1'b0;

	dhcp_frame_byte_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.record_kind  (record_kind),
		.field_id     (field_id),
		.field_value  (field_value),
		.byte_offset  (byte_offset),
		.option_code  (option_code),
		.option_length(option_length),
		.frame_status (frame_status),
		.last         (last),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #2 clk = ~clk;

	// parser state as the testbench tracks it, starting from reset values
	logic        name_on   = 1'b1;
	logic [7:0]  byte_pos  = 8'd0;
	logic [31:0] shift_acc = 32'd0;
	opt_phase_t  opt_phase = PH_CODE;
	logic [7:0]  cur_code  = 8'd0;
	logic [7:0]  cur_len   = 8'd0;
	logic [7:0]  data_idx  = 8'd0;
	logic        cookie_ok = 1'b0;
	logic        opts_done = 1'b0;

	byte_item_t pending_bytes[$];   // bytes waiting for the driver
	rec_t       expected_recs[$];   // records the parser still owes
	logic [7:0] frame_buf[$];       // frame under construction
	int         unaccepted   = 0;   // queued bytes not yet taken by the parser
	int         queued_total = 0;
	int         errors       = 0;

	// handshake pacing
	int         in_gap = 0, in_burst = 0;
	int         stall_left = 0, stall_burst = 0;
	byte_item_t next_item;

	// ------------------------------------------------------------------
	// byte parser prediction: one accepted byte in, zero to two records out
	// ------------------------------------------------------------------
	task automatic parse_byte(input logic [7:0] b, input logic fe);
		rec_t       r;
		logic [7:0] pos;
		logic [7:0] want;
		logic [1:0] st;
		logic       hit;
		pos       = byte_pos;
		shift_acc = {shift_acc[23:0], b};
		r         = '0;
		hit       = 1'b0;
		if (pos < FIXED_LEN) begin
			hit           = 1'b1;
			r.record_kind = KIND_HEADER;
			case (pos)
				8'd0: begin r.field_id = FID_OP;    r.field_value = {24'd0, b}; end
				8'd1: begin r.field_id = FID_HTYPE; r.field_value = {24'd0, b}; end
				8'd2: begin r.field_id = FID_HLEN;  r.field_value = {24'd0, b}; end
				8'd3: begin r.field_id = FID_HOPS;  r.field_value = {24'd0, b}; end
				// multi-byte fields complete on their last byte
				8'd7: begin r.field_id = FID_XID;   r.field_value = shift_acc; end
				8'd9: begin r.field_id = FID_SECS;  r.field_value = {16'd0, shift_acc[15:0]}; end
				// flags high byte: only the broadcast bit matters, low byte is silent
				8'd10: begin r.field_id = FID_BCAST; r.field_value = {31'd0, b[BCAST_BIT]}; end
				8'd15: begin r.field_id = FID_CIADDR; r.field_value = shift_acc; end
				8'd19: begin r.field_id = FID_YIADDR; r.field_value = shift_acc; end
				8'd23: begin r.field_id = FID_SIADDR; r.field_value = shift_acc; end
				8'd27: begin r.field_id = FID_GIADDR; r.field_value = shift_acc; end
				default: begin
					hit = 1'b0;
					if (pos >= CHADDR_START && name_on) begin
						hit           = 1'b1;
						r.record_kind = KIND_NAME;
						r.field_value = {24'd0, b};
						if (pos < SNAME_START) begin
							r.field_id    = FID_CHADDR;
							r.byte_offset = pos - CHADDR_START;
						end else if (pos < FILE_START) begin
							r.field_id    = FID_SNAME;
							r.byte_offset = pos - SNAME_START;
						end else begin
							r.field_id    = FID_FILE;
							r.byte_offset = pos - FILE_START;
						end
					end
				end
			endcase
		end else if (pos < OPTS_START) begin
			// magic cookie: first byte sets the flag, the rest can only clear it
			want = (pos == FIXED_LEN) ? COOKIE_A :
				(pos == FIXED_LEN + 8'd1) ? COOKIE_B :
				(pos == FIXED_LEN + 8'd2) ? COOKIE_C : COOKIE_A;
			if (pos == FIXED_LEN)
				cookie_ok = (b == want);
			else if (b != want)
				cookie_ok = 1'b0;
		end else if (cookie_ok && !opts_done) begin
			case (opt_phase)
				PH_LEN: begin
					cur_len         = b;
					hit             = 1'b1;
					r.record_kind   = KIND_OPT_START;
					r.option_code   = cur_code;
					r.option_length = b;
					data_idx        = 8'd0;
					// zero-length option has its start record only
					opt_phase       = (b == 8'd0) ? PH_CODE : PH_DATA;
				end
				PH_DATA: begin
					hit             = 1'b1;
					r.record_kind   = KIND_OPT_DATA;
					r.field_value   = {24'd0, b};
					r.byte_offset   = data_idx;
					r.option_code   = cur_code;
					r.option_length = cur_len;
					data_idx        = data_idx + 8'd1;
					if (data_idx >= cur_len)
						opt_phase = PH_CODE;
				end
				default: begin
					// expecting a code: end stops the walk, pad is skipped
					if (b == OPT_END) begin
						opts_done = 1'b1;
						opt_phase = PH_CODE;
					end else if (b != OPT_PAD) begin
						cur_code  = b;
						opt_phase = PH_LEN;
					end else begin
						opt_phase = PH_CODE;
					end
				end
			endcase
		end
		if (hit)
			expected_recs.push_back(r);
		if (byte_pos < OPTS_START)
			byte_pos = byte_pos + 8'd1;
		if (fe) begin
			// frame status from the saturated byte count
			if (byte_pos < FIXED_LEN)
				st = ST_SHORT;
			else if (byte_pos == FIXED_LEN)
				st = ST_OK;
			else if (byte_pos < OPTS_START || !cookie_ok)
				st = ST_BAD_COOKIE;
			else
				st = opts_done ? ST_OK : ST_NO_END;
			r                = '0;
			r.record_kind    = KIND_STATUS;
			r.frame_status   = st;
			r.last           = 1'b1;
			expected_recs.push_back(r);
			byte_pos  = 8'd0;
			shift_acc = 32'd0;
			opt_phase = PH_CODE;
			cur_code  = 8'd0;
			cur_len   = 8'd0;
			data_idx  = 8'd0;
			cookie_ok = 1'b0;
			opts_done = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// mismatch reporting and record comparison
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want_v);
		if (got !== want_v)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want_v));
	endtask

	task automatic check_record();
		rec_t want;
		if (expected_recs.size() == 0) begin
			report_mismatch($sformatf("record with nothing pending: kind %0d field %0d value %0h",
				record_kind, field_id, field_value));
		end else begin
			want = expected_recs.pop_front();
			compare_field("record_kind", 32'(record_kind), 32'(want.record_kind));
			compare_field("field_id", 32'(field_id), 32'(want.field_id));
			compare_field("field_value", field_value, want.field_value);
			compare_field("byte_offset", 32'(byte_offset), 32'(want.byte_offset));
			compare_field("option_code", 32'(option_code), 32'(want.option_code));
			compare_field("option_length", 32'(option_length), 32'(want.option_length));
			compare_field("frame_status", 32'(frame_status), 32'(want.frame_status));
			compare_field("last", 32'(last), 32'(want.last));
		end
	endtask

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// driver: feeds queued bytes, holds the payload while stalled
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				parse_byte(data_byte, frame_end);
				unaccepted--;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					next_item = pending_bytes.pop_front();
					data_byte <= next_item.value;
					frame_end <= next_item.fend;
					in_valid  <= 1'b1;
					// occasional back-to-back stretches with no idle cycles
					if (in_burst > 0) begin
						in_burst--;
						in_gap = 0;
					end else begin
						in_gap = pick_gap();
						if ($urandom_range(0, 29) == 0)
							in_burst = $urandom_range(16, 160);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks every accepted record, stalls at random
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_record();
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (stall_burst > 0) begin
					stall_burst--;
					stall_left = 0;
				end else begin
					stall_left = pick_gap();
					if ($urandom_range(0, 29) == 0)
						stall_burst = $urandom_range(16, 160);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// frame construction
	// ------------------------------------------------------------------
	// random byte leaning toward the extremes
	function automatic logic [7:0] rand_byte();
		int         r;
		logic [7:0] v;
		r = $urandom_range(0, 7);
		if (r == 0)
			v = 8'h00;
		else if (r == 1)
			v = 8'hFF;
		else
			v = 8'($urandom_range(0, 255));
		return v;
	endfunction

	function automatic logic [7:0] rand_code();
		int         r;
		logic [7:0] c;
		r = $urandom_range(0, 9);
		if (r == 0)
			c = 8'd1;
		else if (r == 1)
			c = 8'd254;
		else
			c = 8'($urandom_range(1, 254));
		return c;
	endfunction

	// mostly short options, some empty, a rare full-length one
	function automatic int rand_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return 0;
		if (r == 2)
			return 255;
		return $urandom_range(1, 6);
	endfunction

	// fixed part; fill below zero means random content
	task automatic add_header(input int n, input logic bc, input int fill);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = (fill < 0) ? rand_byte() : fill[7:0];
			if (i == 10)
				b[BCAST_BIT] = bc;
			frame_buf.push_back(b);
		end
	endtask

	// first n cookie bytes, one of them corrupted when bad is set
	task automatic add_cookie(input int n, input logic bad);
		logic [7:0] ck[4];
		logic [7:0] flip;
		int         k;
		ck = '{COOKIE_A, COOKIE_B, COOKIE_C, COOKIE_A};
		if (bad) begin
			k      = $urandom_range(0, n - 1);
			flip   = 8'($urandom_range(1, 255));
			ck[k]  = ck[k] ^ flip;
		end
		for (int i = 0; i < n; i++)
			frame_buf.push_back(ck[i]);
	endtask

	// code, length, data; keep cuts the option short when non-negative
	task automatic add_option(input logic [7:0] code, input int len, input int keep);
		int total;
		total = 2 + len;
		if (keep >= 0 && keep < total)
			total = keep;
		for (int i = 0; i < total; i++)
			frame_buf.push_back((i == 0) ? code : (i == 1) ? len[7:0] : rand_byte());
	endtask

	task automatic add_options(input int n, input logic cut);
		int len;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 6) == 0) begin
				frame_buf.push_back(OPT_PAD);
			end else begin
				len = rand_len();
				add_option(rand_code(), len,
					(cut && i == n - 1) ? $urandom_range(1, len + 1) : -1);
			end
		end
	endtask

	// move the built frame to the driver, frame_end on its last byte
	task automatic close_frame();
		byte_item_t it;
		foreach (frame_buf[i]) begin
			it.value = frame_buf[i];
			it.fend  = (i == frame_buf.size() - 1);
			pending_bytes.push_back(it);
		end
		unaccepted   += frame_buf.size();
		queued_total += frame_buf.size();
		frame_buf.delete();
	endtask

	// well-formed frames with random content in about half the cases, the rest header-only, short or broken
	task automatic rand_frame();
		int   shape;
		logic bc;
		shape = $urandom_range(0, 99);
		bc    = 1'($urandom_range(0, 1));
		if (shape < 15) begin
			add_header($urandom_range(1, 235), bc, -1);
		end else if (shape < 20) begin
			add_header(FIXED_LEN, bc, -1);
		end else if (shape < 27) begin
			add_header(FIXED_LEN, bc, -1);
			add_cookie($urandom_range(1, 3), 1'($urandom_range(0, 1)));
		end else if (shape < 37) begin
			// wrong cookie, option-like bytes after it must stay silent
			add_header(FIXED_LEN, bc, -1);
			add_cookie(4, 1'b1);
			add_options($urandom_range(0, 3), 1'b0);
		end else if (shape < 52) begin
			// no end option, sometimes with the last option cut short
			add_header(FIXED_LEN, bc, -1);
			add_cookie(4, 1'b0);
			add_options($urandom_range(0, 5), 1'($urandom_range(0, 1)));
		end else begin
			add_header(FIXED_LEN, bc, -1);
			add_cookie(4, 1'b0);
			add_options($urandom_range(0, 6), 1'b0);
			frame_buf.push_back(OPT_END);
			repeat ($urandom_range(0, 4))
				frame_buf.push_back(rand_byte());
		end
		close_frame();
	endtask

	task automatic run_random(input int nbytes);
		int base;
		base = queued_total;
		while (queued_total - base < nbytes)
			rand_frame();
	endtask

	// all bytes taken and all records back, then let the pipeline drain
	task automatic wait_idle();
		while (unaccepted != 0 || expected_recs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_name_cfg(input logic v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		name_on      = v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		// single-byte frames at both byte extremes
		frame_buf.push_back(8'hFF);
		close_frame();
		frame_buf.push_back(8'h00);
		close_frame();
		// short frame of all ones past the broadcast flag
		add_header(12, 1'b1, 255);
		close_frame();
		// exactly the fixed part, all zeros: no cookie, status ok
		add_header(FIXED_LEN, 1'b0, 0);
		close_frame();
		// good frame: pad, empty option, full-length option, short option, end, ignored tail
		add_header(FIXED_LEN, 1'b1, -1);
		add_cookie(4, 1'b0);
		frame_buf.push_back(OPT_PAD);
		add_option(8'd1, 0, -1);
		add_option(8'd254, 255, -1);
		add_option(rand_code(), 3, -1);
		frame_buf.push_back(OPT_END);
		add_option(8'd12, 2, -1);
		close_frame();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// random frames with name bytes off, then on again
		write_name_cfg(1'b0);
		run_random(200);
		wait_idle();
		write_name_cfg(1'b1);
		run_random(200);
		wait_idle();
		repeat (16) @(posedge clk);

		if (errors == 0)
			$display("PASS dhcp_frame_byte_parser");
		else
			$display("FAIL dhcp_frame_byte_parser");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#4000000;
		$display("FAIL dhcp_frame_byte_parser");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/dfbp_pkg.sv
rtl/core/dfbp_front.sv
rtl/core/dfbp_queue.sv
rtl/core/dfbp_back.sv
rtl/core/dhcp_frame_byte_parser.sv
verif/tb.sv
